### rtl/ssp_pkg.sv
// types and constants shared by the servo status packet parser
package ssp_pkg;

   localparam logic [7:0] HEADER_BYTE  = 8'hFF;
   localparam logic [7:0] LEN_OVERHEAD = 8'd2;

   typedef enum logic [6:0] {
      PH_HDR0  = 7'b0000001,
      PH_HDR1  = 7'b0000010,
      PH_ID    = 7'b0000100,
      PH_LEN   = 7'b0001000,
      PH_ERR   = 7'b0010000,
      PH_PARAM = 7'b0100000,
      PH_CSUM  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic        packet_ok;
      logic [7:0]  servo_id;
      logic [7:0]  error_flags;
      logic [7:0]  param_count;
      logic [15:0] position;
   } result_type;

endpackage

### rtl/ssp_fsm.sv
// packet parsing state machine with running checksum and held fields
module ssp_fsm
   import ssp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output logic       res_valid,
   output result_type res
);

   phase_type  phase_ff, phase_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] expected_ff, expected_in;
   logic [7:0] seen_ff, seen_in;
   logic [7:0] id_ff, id_in;
   logic [7:0] error_ff, error_in;
   logic [7:0] pos_lo_ff, pos_lo_in;
   logic [7:0] pos_hi_ff, pos_hi_in;
   logic [7:0] sum_add;

   assign sum_add = sum_ff + rx_byte;

   always_comb begin
      phase_in    = phase_ff;
      sum_in      = sum_ff;
      expected_in = expected_ff;
      seen_in     = seen_ff;
      id_in       = id_ff;
      error_in    = error_ff;
      pos_lo_in   = pos_lo_ff;
      pos_hi_in   = pos_hi_ff;
      res_valid   = 1'b0;
      unique case (phase_ff)
         PH_HDR1: begin
            phase_in = (rx_byte == HEADER_BYTE) ? PH_ID : PH_HDR0;
         end
         PH_ID: begin
            id_in    = rx_byte;
            sum_in   = rx_byte;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            expected_in = rx_byte - LEN_OVERHEAD;
            sum_in      = sum_add;
            phase_in    = PH_ERR;
         end
         PH_ERR: begin
            error_in = rx_byte;
            sum_in   = sum_add;
            seen_in  = 8'd0;
            phase_in = (expected_ff != 8'd0) ? PH_PARAM : PH_CSUM;
         end
         PH_PARAM: begin
            sum_in = sum_add;
            if (seen_ff == 8'd0) begin
               pos_lo_in = rx_byte;
            end
            if (seen_ff == 8'd1) begin
               pos_hi_in = rx_byte;
            end
            if (seen_ff == expected_ff - 8'd1) begin
               phase_in = PH_CSUM;
            end
            seen_in = seen_ff + 8'd1;
         end
         PH_CSUM: begin
            res_valid = 1'b1;
            phase_in  = PH_HDR0;
         end
         default: begin
            phase_in = (rx_byte == HEADER_BYTE) ? PH_HDR1 : PH_HDR0;
         end
      endcase
   end

   assign res.packet_ok   = (~sum_ff == rx_byte);
   assign res.servo_id    = id_ff;
   assign res.error_flags = error_ff;
   assign res.param_count = expected_ff;
   assign res.position    = {pos_hi_ff, pos_lo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR0;
         sum_ff      <= 8'd0;
         expected_ff <= 8'd0;
         seen_ff     <= 8'd0;
         id_ff       <= 8'd0;
         error_ff    <= 8'd0;
         pos_lo_ff   <= 8'd0;
         pos_hi_ff   <= 8'd0;
      end else if (step) begin
         phase_ff    <= phase_in;
         sum_ff      <= sum_in;
         expected_ff <= expected_in;
         seen_ff     <= seen_in;
         id_ff       <= id_in;
         error_ff    <= error_in;
         pos_lo_ff   <= pos_lo_in;
         pos_hi_ff   <= pos_hi_in;
      end
   end

   a_csum_returns: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_CSUM |=> phase_ff == PH_HDR0)
      else $error("checksum byte did not return to header hunt");

   a_zero_params: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_ERR && expected_ff == 8'd0 |=> phase_ff == PH_CSUM)
      else $error("empty packet did not go to checksum");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(sum_ff))
      else $error("state moved without a request");

endmodule

### rtl/servo_status_packet_parser.sv
// top level: input register, packet parser and result register
// a checksum byte is held in the input register, its result then in the result register
// throughput: one byte per cycle while the result register is free or being read
// a full result register stalls the input register only while its result is not taken
// synchronous active-high reset returns the parser to header hunting with all fields zero
module servo_status_packet_parser
   import ssp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_packet_ok,
   output logic [7:0]  rsp_servo_id,
   output logic [7:0]  rsp_error_flags,
   output logic [7:0]  rsp_param_count,
   output logic [15:0] rsp_position
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff;
   logic       out_free;
   logic       advance;
   logic       res_valid;
   result_type res;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   ssp_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_packet_ok   = out_ff.packet_ok;
   assign rsp_servo_id    = out_ff.servo_id;
   assign rsp_error_flags = out_ff.error_flags;
   assign rsp_param_count = out_ff.param_count;
   assign rsp_position    = out_ff.position;

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled request byte lost");

   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance && res_valid))
      else $error("result appeared without a checksum byte");

endmodule
